>>> hw/rtl/i2cms_pkg.sv
package i2cms_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       ack_timeout;
    logic       ack_valid;
  } out_item_t;

  // classified step as it sits in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } step_t;

  localparam logic [7:0] ACK_LIMIT_RST = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [2:0] PH_0 = 3'd0;
  localparam logic [2:0] PH_1 = 3'd1;
  localparam logic [2:0] PH_2 = 3'd2;
  localparam logic [2:0] PH_3 = 3'd3;
  localparam logic [2:0] PH_4 = 3'd4;
  localparam logic [2:0] PH_5 = 3'd5;
  localparam logic [2:0] PH_6 = 3'd6;

endpackage

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
// a step accepted is registered in the queue and then, when popped, in the output register
// one step per cycle unless out_stall holds the output; the sequencer moves on each pop
// a two-entry queue between classifier and sequencer lets either side stall alone
// reset (synchronous, rst_n low): sequencer idle, scl and sda released high,
// queue and output register empty, ack timeout limit 250
module i2c_master_bit_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cms_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cms_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  logic             q_valid;
  logic             q_pop;
  i2cms_pkg::step_t q_data;

  i2cms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/i2cms_front.sv
module i2cms_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cms_pkg::in_item_t in_data,
  output logic                q_valid,
  input  logic                q_pop,
  output i2cms_pkg::step_t    q_data
);

  i2cms_pkg::step_t mem_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             push;
  logic             pop;
  i2cms_pkg::step_t cls;

  // undefined op codes fall back to a plain tick
  always_comb begin
    cls.tx_byte  = in_data.tx_byte;
    cls.send_ack = in_data.send_ack;
    cls.sda_in   = in_data.sda_in;
    if (in_data.op inside {[i2cms_pkg::CMD_START:i2cms_pkg::CMD_WAIT]}) begin
      cls.cmd = i2cms_pkg::cmd_t'(in_data.op);
    end else begin
      cls.cmd = i2cms_pkg::CMD_IDLE;
    end
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> hw/rtl/i2cms_back.sv
module i2cms_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  i2cms_pkg::step_t     q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cms_pkg::out_item_t out_data
);

  logic [7:0]           limit_r;
  i2cms_pkg::cmd_t      cmd_r, cmd_nxt, cmd_b;
  logic [2:0]           phase_r, phase_nxt, phase_b;
  logic [3:0]           bit_cnt_r, bit_cnt_nxt, bit_cnt_b;
  logic [7:0]           shift_r, shift_nxt, shift_b;
  logic [7:0]           poll_r, poll_nxt, poll_b;
  logic                 ack_choice_r, ack_choice_nxt, ack_choice_b;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 out_valid_r;
  i2cms_pkg::out_item_t out_data_r;
  logic                 rx_pulse;
  logic                 ack_pulse;
  logic                 ack_to;

  // the output register frees up when its transfer completes
  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // command latch when idle
  always_comb begin
    cmd_b        = cmd_r;
    phase_b      = phase_r;
    bit_cnt_b    = bit_cnt_r;
    shift_b      = shift_r;
    poll_b       = poll_r;
    ack_choice_b = ack_choice_r;
    if (cmd_r == i2cms_pkg::CMD_IDLE && q_data.cmd != i2cms_pkg::CMD_IDLE) begin
      cmd_b        = q_data.cmd;
      phase_b      = i2cms_pkg::PH_0;
      bit_cnt_b    = 4'd0;
      poll_b       = 8'd0;
      shift_b      = (q_data.cmd == i2cms_pkg::CMD_WRITE) ? q_data.tx_byte : 8'd0;
      ack_choice_b = q_data.send_ack;
    end
  end

  // next state
  always_comb begin
    cmd_nxt        = cmd_b;
    phase_nxt      = phase_b;
    bit_cnt_nxt    = bit_cnt_b;
    shift_nxt      = shift_b;
    poll_nxt       = poll_b;
    ack_choice_nxt = ack_choice_b;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    case (cmd_b)
      i2cms_pkg::CMD_IDLE: begin
      end
      i2cms_pkg::CMD_START: begin
        if (phase_b == i2cms_pkg::PH_0) begin
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_1;
        end else if (phase_b == i2cms_pkg::PH_1) begin
          sda_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_2;
        end else begin
          scl_nxt   = 1'b0;
          cmd_nxt   = i2cms_pkg::CMD_IDLE;
          phase_nxt = i2cms_pkg::PH_0;
        end
      end
      i2cms_pkg::CMD_STOP: begin
        if (phase_b == i2cms_pkg::PH_0) begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_1;
        end else if (phase_b == i2cms_pkg::PH_1) begin
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_2;
        end else begin
          sda_nxt   = 1'b1;
          cmd_nxt   = i2cms_pkg::CMD_IDLE;
          phase_nxt = i2cms_pkg::PH_0;
        end
      end
      i2cms_pkg::CMD_WRITE: begin
        if (phase_b == i2cms_pkg::PH_0) begin
          scl_nxt   = 1'b0;
          sda_nxt   = shift_b[7];
          phase_nxt = i2cms_pkg::PH_1;
        end else if (phase_b == i2cms_pkg::PH_1) begin
          scl_nxt     = 1'b1;
          shift_nxt   = {shift_b[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_b + 4'd1;
          phase_nxt   = (bit_cnt_nxt >= i2cms_pkg::BITS_PER_BYTE) ?
                        i2cms_pkg::PH_2 : i2cms_pkg::PH_0;
        end else if (phase_b == i2cms_pkg::PH_2) begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_3;
        end else begin
          sda_nxt   = 1'b1;
          cmd_nxt   = i2cms_pkg::CMD_IDLE;
          phase_nxt = i2cms_pkg::PH_0;
        end
      end
      i2cms_pkg::CMD_READ: begin
        case (phase_b)
          i2cms_pkg::PH_0: begin
            sda_nxt   = 1'b1;
            phase_nxt = i2cms_pkg::PH_1;
          end
          i2cms_pkg::PH_1: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cms_pkg::PH_2;
          end
          i2cms_pkg::PH_2: begin
            shift_nxt   = {shift_b[6:0], q_data.sda_in};
            scl_nxt     = 1'b0;
            bit_cnt_nxt = bit_cnt_b + 4'd1;
            phase_nxt   = (bit_cnt_nxt >= i2cms_pkg::BITS_PER_BYTE) ?
                          i2cms_pkg::PH_3 : i2cms_pkg::PH_1;
          end
          i2cms_pkg::PH_3: begin
            sda_nxt   = !ack_choice_b;
            phase_nxt = i2cms_pkg::PH_4;
          end
          i2cms_pkg::PH_4: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cms_pkg::PH_5;
          end
          i2cms_pkg::PH_5: begin
            scl_nxt = 1'b0;
            if (ack_choice_b) begin
              phase_nxt = i2cms_pkg::PH_6;
            end else begin
              cmd_nxt   = i2cms_pkg::CMD_IDLE;
              phase_nxt = i2cms_pkg::PH_0;
            end
          end
          default: begin
            sda_nxt   = 1'b1;
            cmd_nxt   = i2cms_pkg::CMD_IDLE;
            phase_nxt = i2cms_pkg::PH_0;
          end
        endcase
      end
      i2cms_pkg::CMD_WAIT: begin
        case (phase_b)
          i2cms_pkg::PH_0: begin
            sda_nxt   = 1'b1;
            phase_nxt = i2cms_pkg::PH_1;
          end
          i2cms_pkg::PH_1: begin
            scl_nxt   = 1'b1;
            poll_nxt  = 8'd0;
            phase_nxt = i2cms_pkg::PH_2;
          end
          i2cms_pkg::PH_2: begin
            if (!q_data.sda_in) begin
              scl_nxt   = 1'b0;
              cmd_nxt   = i2cms_pkg::CMD_IDLE;
              phase_nxt = i2cms_pkg::PH_0;
            end else if (poll_b >= limit_r) begin
              // timeout: go into a stop sequence
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = i2cms_pkg::PH_3;
            end else begin
              poll_nxt = poll_b + 8'd1;
            end
          end
          i2cms_pkg::PH_3: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cms_pkg::PH_4;
          end
          default: begin
            sda_nxt   = 1'b1;
            cmd_nxt   = i2cms_pkg::CMD_IDLE;
            phase_nxt = i2cms_pkg::PH_0;
          end
        endcase
      end
      default: begin
        cmd_nxt   = i2cms_pkg::CMD_IDLE;
        phase_nxt = i2cms_pkg::PH_0;
      end
    endcase
  end

  // completion flags
  always_comb begin
    rx_pulse  = 1'b0;
    ack_pulse = 1'b0;
    ack_to    = 1'b0;
    case (cmd_b)
      i2cms_pkg::CMD_READ: begin
        rx_pulse = (phase_b == i2cms_pkg::PH_5 && !ack_choice_b) ||
                   (phase_b >= i2cms_pkg::PH_6);
      end
      i2cms_pkg::CMD_WAIT: begin
        ack_to    = (phase_b >= i2cms_pkg::PH_4);
        ack_pulse = (phase_b == i2cms_pkg::PH_2 && !q_data.sda_in) || ack_to;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= i2cms_pkg::ACK_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r        <= i2cms_pkg::CMD_IDLE;
      phase_r      <= i2cms_pkg::PH_0;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      poll_r       <= 8'd0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
    end else if (q_pop) begin
      cmd_r        <= cmd_nxt;
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      poll_r       <= poll_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.scl_out     <= scl_nxt;
      out_data_r.sda_out     <= sda_nxt;
      out_data_r.busy_res    <= (cmd_nxt != i2cms_pkg::CMD_IDLE);
      out_data_r.rx_byte     <= rx_pulse ? shift_b : 8'd0;
      out_data_r.rx_valid    <= rx_pulse;
      out_data_r.ack_timeout <= ack_to;
      out_data_r.ack_valid   <= ack_pulse;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r == i2cms_pkg::CMD_IDLE |-> phase_r == i2cms_pkg::PH_0)
    else $error("idle with nonzero phase");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= i2cms_pkg::BITS_PER_BYTE)
    else $error("bit count past one byte");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.rx_valid || out_data_r.ack_valid) |-> !out_data_r.busy_res)
    else $error("completion reported while busy");

  a_held_state: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(cmd_r) && $stable(phase_r) && $stable(scl_r) && $stable(sda_r))
    else $error("sequencer moved without a transfer");
`endif

endmodule

>>> test/tb_i2c_master_bit_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer_unit;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  i2cms_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  i2cms_pkg::out_item_t out_data;
  logic                 cfg_we = 1'b0;
  logic [7:0]           cfg_wdata = '0;

  i2c_master_bit_sequencer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // line sequencer state as the block should hold it
  i2cms_pkg::cmd_t run_cmd   = i2cms_pkg::CMD_IDLE;
  logic [2:0]      step_ph   = i2cms_pkg::PH_0;
  logic [3:0]      bit_cnt   = '0;
  logic [7:0]      shift_q   = '0;
  logic [7:0]      poll_cnt  = '0;
  logic            ack_low   = 1'b0;
  logic            scl_q     = 1'b1;
  logic            sda_q     = 1'b1;
  logic [7:0]      ack_limit = i2cms_pkg::ACK_LIMIT_RST;

  i2cms_pkg::in_item_t  pending_steps[$];
  i2cms_pkg::out_item_t predicted_lines[$];
  int unsigned items_queued = 0;
  int unsigned fail_count = 0;
  int unsigned in_gap = 0, in_calm = 0, out_hold = 0, out_calm = 0;

  function automatic void seq_done();
    run_cmd = i2cms_pkg::CMD_IDLE;
    step_ph = i2cms_pkg::PH_0;
  endfunction

  function automatic i2cms_pkg::out_item_t sequence_line_step(input i2cms_pkg::in_item_t it);
    i2cms_pkg::out_item_t res;
    res = '0;
    if (run_cmd == i2cms_pkg::CMD_IDLE && it.op >= i2cms_pkg::CMD_START &&
        it.op <= i2cms_pkg::CMD_WAIT) begin
      run_cmd  = i2cms_pkg::cmd_t'(it.op);
      step_ph  = i2cms_pkg::PH_0;
      bit_cnt  = '0;
      poll_cnt = '0;
      shift_q  = (it.op == i2cms_pkg::CMD_WRITE) ? it.tx_byte : 8'h00;
      ack_low  = it.send_ack;
    end
    case (run_cmd)
      i2cms_pkg::CMD_IDLE: ;
      i2cms_pkg::CMD_START: begin
        if (step_ph == i2cms_pkg::PH_0) begin
          sda_q = 1'b1; scl_q = 1'b1; step_ph = i2cms_pkg::PH_1;
        end else if (step_ph == i2cms_pkg::PH_1) begin
          sda_q = 1'b0; step_ph = i2cms_pkg::PH_2;
        end else begin
          scl_q = 1'b0; seq_done();
        end
      end
      i2cms_pkg::CMD_STOP: begin
        if (step_ph == i2cms_pkg::PH_0) begin
          scl_q = 1'b0; sda_q = 1'b0; step_ph = i2cms_pkg::PH_1;
        end else if (step_ph == i2cms_pkg::PH_1) begin
          scl_q = 1'b1; step_ph = i2cms_pkg::PH_2;
        end else begin
          sda_q = 1'b1; seq_done();
        end
      end
      i2cms_pkg::CMD_WRITE: begin
        case (step_ph)
          i2cms_pkg::PH_0: begin
            scl_q = 1'b0; sda_q = shift_q[7]; step_ph = i2cms_pkg::PH_1;
          end
          i2cms_pkg::PH_1: begin
            scl_q   = 1'b1;
            shift_q = shift_q << 1;
            bit_cnt = bit_cnt + 4'd1;
            step_ph = (bit_cnt >= i2cms_pkg::BITS_PER_BYTE) ? i2cms_pkg::PH_2
                                                            : i2cms_pkg::PH_0;
          end
          i2cms_pkg::PH_2: begin
            scl_q = 1'b0; step_ph = i2cms_pkg::PH_3;
          end
          default: begin
            sda_q = 1'b1; seq_done();
          end
        endcase
      end
      i2cms_pkg::CMD_READ: begin
        case (step_ph)
          i2cms_pkg::PH_0: begin
            sda_q = 1'b1; step_ph = i2cms_pkg::PH_1;
          end
          i2cms_pkg::PH_1: begin
            scl_q = 1'b1; step_ph = i2cms_pkg::PH_2;
          end
          i2cms_pkg::PH_2: begin
            shift_q = {shift_q[6:0], it.sda_in};
            scl_q   = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            step_ph = (bit_cnt >= i2cms_pkg::BITS_PER_BYTE) ? i2cms_pkg::PH_3
                                                            : i2cms_pkg::PH_1;
          end
          i2cms_pkg::PH_3: begin
            sda_q = !ack_low; step_ph = i2cms_pkg::PH_4;
          end
          i2cms_pkg::PH_4: begin
            scl_q = 1'b1; step_ph = i2cms_pkg::PH_5;
          end
          i2cms_pkg::PH_5: begin
            scl_q = 1'b0;
            if (ack_low) begin
              step_ph = i2cms_pkg::PH_6;
            end else begin
              res.rx_byte = shift_q; res.rx_valid = 1'b1; seq_done();
            end
          end
          default: begin
            sda_q = 1'b1;
            res.rx_byte = shift_q; res.rx_valid = 1'b1; seq_done();
          end
        endcase
      end
      i2cms_pkg::CMD_WAIT: begin
        case (step_ph)
          i2cms_pkg::PH_0: begin
            sda_q = 1'b1; step_ph = i2cms_pkg::PH_1;
          end
          i2cms_pkg::PH_1: begin
            scl_q = 1'b1; poll_cnt = '0; step_ph = i2cms_pkg::PH_2;
          end
          i2cms_pkg::PH_2: begin
            if (!it.sda_in) begin
              scl_q = 1'b0; res.ack_valid = 1'b1; seq_done();
            end else if (poll_cnt >= ack_limit) begin
              // no acknowledge in time: fall into a stop condition
              scl_q = 1'b0; sda_q = 1'b0; step_ph = i2cms_pkg::PH_3;
            end else begin
              poll_cnt = poll_cnt + 8'd1;
            end
          end
          i2cms_pkg::PH_3: begin
            scl_q = 1'b1; step_ph = i2cms_pkg::PH_4;
          end
          default: begin
            sda_q = 1'b1;
            res.ack_valid = 1'b1; res.ack_timeout = 1'b1; seq_done();
          end
        endcase
      end
      default: seq_done();
    endcase
    res.scl_out  = scl_q;
    res.sda_out  = sda_q;
    res.busy_res = (run_cmd != i2cms_pkg::CMD_IDLE);
    return res;
  endfunction

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 2) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_line(input i2cms_pkg::out_item_t got);
    i2cms_pkg::out_item_t want;
    if (predicted_lines.size() == 0) begin
      $display("%0t: out transfer with none pending, expected none actual %h", $time, got);
      fail_count++;
    end else begin
      want = predicted_lines.pop_front();
      check_field("scl_out", want.scl_out, got.scl_out);
      check_field("sda_out", want.sda_out, got.sda_out);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("rx_byte", want.rx_byte, got.rx_byte);
      check_field("rx_valid", want.rx_valid, got.rx_valid);
      check_field("ack_timeout", want.ack_timeout, got.ack_timeout);
      check_field("ack_valid", want.ack_valid, got.ack_valid);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_lines.push_back(sequence_line_step(in_data));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || pending_steps.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_steps.pop_front();
          in_valid <= 1'b1;
          in_gap = idle_len(in_calm);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_line(out_data);
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_hold = idle_len(out_calm);
      end
    end
  end

  // command step followed by fill ticks; the line reads high for the first
  // high_for steps and low after, or random bits when high_for is negative
  task automatic queue_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                               input int unsigned fill, input int high_for,
                               input int unsigned noise);
    i2cms_pkg::in_item_t it;
    for (int k = 0; k <= int'(fill); k++) begin
      if (k == 0) begin
        it.op       = op;
        it.tx_byte  = tx;
        it.send_ack = ack;
      end else begin
        it.op       = ($urandom_range(0, 99) < noise) ? 3'($urandom_range(0, 7))
                                                      : 3'(i2cms_pkg::CMD_IDLE);
        it.tx_byte  = 8'($urandom_range(0, 255));
        it.send_ack = 1'($urandom_range(0, 1));
      end
      it.sda_in = (high_for < 0) ? 1'($urandom_range(0, 1)) : (k < high_for);
      pending_steps.push_back(it);
      items_queued++;
    end
  endtask

  task automatic queue_random_command();
    int unsigned pick, fill, polls, trim;
    int          high_for;
    logic [2:0]  op;
    logic        ack;
    pick     = $urandom_range(0, 99);
    ack      = 1'($urandom_range(0, 1));
    high_for = -1;
    if (pick < 8) begin
      // stray ticks, undefined codes among them
      op   = $urandom_range(0, 1) ? 3'(i2cms_pkg::CMD_IDLE) : 3'($urandom_range(6, 7));
      fill = $urandom_range(0, 3);
    end else if (pick < 22) begin
      op = i2cms_pkg::CMD_START; fill = 2;
    end else if (pick < 36) begin
      op = i2cms_pkg::CMD_STOP; fill = 2;
    end else if (pick < 56) begin
      op = i2cms_pkg::CMD_WRITE; fill = 17;
    end else if (pick < 76) begin
      op   = i2cms_pkg::CMD_READ;
      fill = ack ? 20 : 19;
    end else begin
      op = i2cms_pkg::CMD_WAIT;
      if ($urandom_range(0, 3) == 0) begin
        fill     = ack_limit + 4;
        high_for = fill + 1;
      end else begin
        polls    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ack_limit)
                                               : $urandom_range(0, (ack_limit < 4) ? ack_limit : 4);
        fill     = 2 + polls;
        high_for = 2 + polls;
      end
    end
    // cut short so the next command lands while busy, or pad with idle ticks
    trim = $urandom_range(0, 9);
    if (trim == 0 && fill > 3) fill -= $urandom_range(1, 3);
    else if (trim < 3) fill += $urandom_range(1, 4);
    queue_command(op, 8'($urandom_range(0, 255)), ack, fill, high_for, 6);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_steps.size() != 0 || in_valid || predicted_lines.size() != 0);
  endtask

  task automatic set_limit(input logic [7:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ack_limit = value;
  endtask

  initial begin
    int unsigned phase_no, cmds, roll;
    phase_no = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_command(i2cms_pkg::CMD_IDLE, 8'h00, 1'b0, 0, 0, 0);
    queue_command(i2cms_pkg::CMD_IDLE, 8'hFF, 1'b1, 0, 1, 0);
    queue_command(3'd6, 8'h3C, 1'b0, 0, -1, 0);
    queue_command(3'd7, 8'hC3, 1'b1, 0, -1, 0);
    queue_command(i2cms_pkg::CMD_START, 8'h00, 1'b0, 2, -1, 0);
    queue_command(i2cms_pkg::CMD_WRITE, 8'h00, 1'b0, 17, -1, 0);
    queue_command(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b1, 17, -1, 0);
    // stop arrives in the middle of a write and is dropped
    queue_command(i2cms_pkg::CMD_WRITE, 8'hA5, 1'b0, 4, -1, 0);
    queue_command(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 14, -1, 0);
    queue_command(i2cms_pkg::CMD_WAIT, 8'h00, 1'b0, 2, 2, 0);
    queue_command(i2cms_pkg::CMD_WAIT, 8'h00, 1'b0, 5, 5, 0);
    queue_command(i2cms_pkg::CMD_READ, 8'h00, 1'b1, 20, -1, 0);
    queue_command(i2cms_pkg::CMD_READ, 8'h00, 1'b0, 19, 100, 0);
    queue_command(i2cms_pkg::CMD_READ, 8'h00, 1'b1, 20, 0, 0);
    queue_command(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 2, -1, 0);

    set_limit(8'd1);
    queue_command(i2cms_pkg::CMD_WAIT, 8'h00, 1'b0, 5, 100, 0);
    queue_command(i2cms_pkg::CMD_WAIT, 8'h00, 1'b0, 3, 3, 0);
    queue_command(i2cms_pkg::CMD_START, 8'h00, 1'b0, 2, -1, 0);
    queue_command(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 2, -1, 0);

    set_limit(8'd255);
    queue_command(i2cms_pkg::CMD_WAIT, 8'h00, 1'b0, 259, 300, 0);
    repeat (10) queue_random_command();

    while (items_queued < 1650) begin
      roll = $urandom_range(0, 9);
      if (phase_no == 0) set_limit(i2cms_pkg::ACK_LIMIT_RST);
      else if (roll < 7) set_limit(8'($urandom_range(1, 6)));
      else if (roll < 9) set_limit(8'($urandom_range(7, 30)));
      else set_limit(8'($urandom_range(31, 255)));
      cmds = $urandom_range(15, 40);
      repeat (cmds) queue_random_command();
      phase_no++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule
